/* sv/mrwt_pkg.sv */
// ----------------------------------------------------------------------------
// Miller-Rabin witness test package
// Shared widths, state encoding and controller/datapath interface structs.
// ----------------------------------------------------------------------------
package mrwt_pkg;

	localparam int Width = 32;
	localparam int CntW = $clog2(Width + 1);

	typedef logic [Width-1:0] word_t;
	typedef logic [CntW-1:0] cnt_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RED,
		ST_CHECK,
		ST_SPLIT,
		ST_PSTEP,
		ST_PMUL,
		ST_PSQR,
		ST_EVAL,
		ST_SQR,
		ST_SEVAL,
		ST_DONE
	} state_t;

	// Operations that the controller asks of the datapath.
	typedef enum logic [2:0] {
		OP_NONE,
		OP_LOAD,
		OP_RED_STEP,
		OP_SPLIT,
		OP_MUL_START,
		OP_MUL_STEP,
		OP_SHIFT_E
	} op_t;

	// Multiplier operand selection.
	typedef enum logic [1:0] {
		MS_Y_B,
		MS_B_B,
		MS_Y_Y
	} msel_t;

	typedef struct packed {
		op_t   op;
		msel_t msel;
		logic  wr_y;
		logic  wr_b;
	} cmd_t;

	typedef struct packed {
		logic small_n;
		logic n_is_prime_small;
		logic n_even;
		logic red_done;
		logic base_deg;
		logic split_done;
		logic e_zero;
		logic e_lsb;
		logic mul_done;
		logic y_is_one;
		logic y_is_nm1;
		logic s_left;
	} stat_t;

endpackage

/* sv/mrwt_datapath.sv */
// ----------------------------------------------------------------------------
// Miller-Rabin datapath
// Operand registers, bit-serial reduction of the base, trailing-zero split
// of n-1 and a shift-and-add modular multiplier, one bit per cycle.
// ----------------------------------------------------------------------------
module mrwt_datapath (
	input  logic                  clk,
	input  logic [31:0]           candidate,
	input  logic [31:0]           witness,
	input  mrwt_pkg::cmd_t        cmd,
	output mrwt_pkg::stat_t       stat
);

	mrwt_pkg::word_t n_q, nm1_q, e_q, b_q, y_q, rem_q, wsh_q;
	mrwt_pkg::word_t mx_q, my_q, acc_q;
	mrwt_pkg::cnt_t  red_cnt_q, s_q;

	logic [mrwt_pkg::Width:0] rem_sh;
	mrwt_pkg::word_t acc_add, mx_dbl, room_a, room_x;

	// Reduction step: shift one witness bit into the remainder, then subtract n if the result is at least n.
	always_comb begin
		rem_sh = {rem_q, wsh_q[mrwt_pkg::Width-1]};
	end

	// Modular add helpers, overflow free.
	always_comb begin
		room_a  = n_q - mx_q;
		acc_add = (acc_q >= room_a) ? (acc_q - room_a) : (acc_q + mx_q);
		room_x  = n_q - mx_q;
		mx_dbl  = (mx_q >= room_x) ? (mx_q - room_x) : (mx_q + mx_q);
	end

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			mrwt_pkg::OP_LOAD: begin
				n_q       <= candidate[mrwt_pkg::Width-1:0];
				nm1_q     <= candidate[mrwt_pkg::Width-1:0] - 1'b1;
				wsh_q     <= witness[mrwt_pkg::Width-1:0];
				rem_q     <= '0;
				red_cnt_q <= '0;
				s_q       <= '0;
				y_q       <= mrwt_pkg::word_t'(1);
			end
			mrwt_pkg::OP_RED_STEP: begin
				wsh_q     <= wsh_q << 1;
				red_cnt_q <= red_cnt_q + 1'b1;
				if (rem_sh >= {1'b0, n_q}) begin
					rem_q <= mrwt_pkg::word_t'(rem_sh - {1'b0, n_q});
				end else begin
					rem_q <= rem_sh[mrwt_pkg::Width-1:0];
				end
			end
			mrwt_pkg::OP_SPLIT: begin
				if (red_cnt_q != '0) begin
					// First split cycle copies the reduced base and n-1 shifted right once.
					b_q       <= rem_q;
					e_q       <= nm1_q >> 1;
					s_q       <= mrwt_pkg::cnt_t'(1);
					red_cnt_q <= '0;
				end else if (!e_q[0]) begin
					e_q <= e_q >> 1;
					s_q <= s_q + 1'b1;
				end
			end
			mrwt_pkg::OP_MUL_START: begin
				unique case (cmd.msel)
					mrwt_pkg::MS_Y_B: begin
						mx_q <= b_q;
						my_q <= y_q;
					end
					mrwt_pkg::MS_B_B: begin
						mx_q <= b_q;
						my_q <= b_q;
					end
					default: begin
						mx_q <= y_q;
						my_q <= y_q;
					end
				endcase
				acc_q <= '0;
			end
			mrwt_pkg::OP_MUL_STEP: begin
				if (my_q != '0) begin
					if (my_q[0]) begin
						acc_q <= acc_add;
					end
					mx_q <= mx_dbl;
					my_q <= my_q >> 1;
				end else begin
					if (cmd.wr_y) begin
						y_q <= acc_q;
					end
					if (cmd.wr_b) begin
						b_q <= acc_q;
					end
				end
			end
			mrwt_pkg::OP_SHIFT_E: begin
				e_q <= e_q >> 1;
				if (s_q != '0 && e_q == '0) begin
					s_q <= s_q - 1'b1;
				end
				// The squared base lands together with the exponent shift.
				if (cmd.wr_b) begin
					b_q <= acc_q;
				end
			end
			default: begin
			end
		endcase
	end

	// Status toward the controller.
	always_comb begin
		stat.small_n          = (n_q < mrwt_pkg::word_t'(2));
		stat.n_is_prime_small = (n_q == mrwt_pkg::word_t'(2)) ||
		                        (n_q == mrwt_pkg::word_t'(3));
		stat.n_even           = !n_q[0];
		stat.red_done         = (red_cnt_q == mrwt_pkg::cnt_t'(mrwt_pkg::Width));
		stat.base_deg         = (rem_q < mrwt_pkg::word_t'(2));
		stat.split_done       = e_q[0];
		stat.e_zero           = (e_q == '0);
		stat.e_lsb            = e_q[0];
		stat.mul_done         = (my_q == '0);
		stat.y_is_one         = (y_q == mrwt_pkg::word_t'(1));
		stat.y_is_nm1         = (y_q == nm1_q);
		stat.s_left           = (s_q > mrwt_pkg::cnt_t'(1));
	end

endmodule

/* sv/mrwt_ctrl.sv */
// ----------------------------------------------------------------------------
// Miller-Rabin controller
// Sequences the small/even checks, reduction, split, exponentiation and the squaring checks.
// ----------------------------------------------------------------------------
module mrwt_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  mrwt_pkg::stat_t   stat,
	output mrwt_pkg::cmd_t    cmd,
	output logic              done,
	output logic              probable_prime,
	output logic              trivial_case
);

	mrwt_pkg::state_t state_q, state_d;
	logic prime_q, prime_d, triv_q, triv_d;
	logic [1:0] sq_q, sq_d;   // squaring count kept by datapath s; this marks first pass

	// State and result flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mrwt_pkg::ST_IDLE;
			prime_q <= 1'b0;
			triv_q  <= 1'b0;
			sq_q    <= '0;
		end else begin
			state_q <= state_d;
			prime_q <= prime_d;
			triv_q  <= triv_d;
			sq_q    <= sq_d;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		prime_d = prime_q;
		triv_d  = triv_q;
		sq_d    = sq_q;
		unique case (state_q)
			mrwt_pkg::ST_IDLE: begin
				if (start) begin
					state_d = mrwt_pkg::ST_CHECK;
				end
			end
			mrwt_pkg::ST_CHECK: begin
				triv_d = 1'b1;
				priority if (stat.small_n) begin
					prime_d = 1'b0;
					state_d = mrwt_pkg::ST_DONE;
				end else if (stat.n_is_prime_small) begin
					prime_d = 1'b1;
					state_d = mrwt_pkg::ST_DONE;
				end else if (stat.n_even) begin
					prime_d = 1'b0;
					state_d = mrwt_pkg::ST_DONE;
				end else begin
					state_d = mrwt_pkg::ST_RED;
				end
			end
			mrwt_pkg::ST_RED: begin
				if (stat.red_done) begin
					if (stat.base_deg) begin
						prime_d = 1'b1;
						state_d = mrwt_pkg::ST_DONE;
					end else begin
						state_d = mrwt_pkg::ST_SPLIT;
					end
				end
			end
			mrwt_pkg::ST_SPLIT: begin
				triv_d = 1'b0;
				sq_d   = 2'd1;
				if (sq_q == 2'd1 && stat.split_done) begin
					state_d = mrwt_pkg::ST_PSTEP;
				end
			end
			mrwt_pkg::ST_PSTEP: begin
				sq_d = 2'd0;
				priority if (stat.e_zero) begin
					state_d = mrwt_pkg::ST_EVAL;
				end else if (stat.e_lsb) begin
					state_d = mrwt_pkg::ST_PMUL;
				end else begin
					state_d = mrwt_pkg::ST_PSQR;
				end
			end
			mrwt_pkg::ST_PMUL: begin
				if (sq_q == 2'd1 && stat.mul_done) begin
					sq_d    = 2'd0;
					state_d = mrwt_pkg::ST_PSQR;
				end else begin
					sq_d = 2'd1;
				end
			end
			mrwt_pkg::ST_PSQR: begin
				if (sq_q == 2'd1 && stat.mul_done) begin
					sq_d    = 2'd0;
					state_d = mrwt_pkg::ST_PSTEP;
				end else begin
					sq_d = 2'd1;
				end
			end
			mrwt_pkg::ST_EVAL: begin
				if (stat.y_is_one || stat.y_is_nm1) begin
					prime_d = 1'b1;
					state_d = mrwt_pkg::ST_DONE;
				end else if (stat.s_left) begin
					state_d = mrwt_pkg::ST_SQR;
				end else begin
					prime_d = 1'b0;
					state_d = mrwt_pkg::ST_DONE;
				end
			end
			mrwt_pkg::ST_SQR: begin
				if (sq_q == 2'd1 && stat.mul_done) begin
					sq_d    = 2'd0;
					state_d = mrwt_pkg::ST_SEVAL;
				end else begin
					sq_d = 2'd1;
				end
			end
			mrwt_pkg::ST_SEVAL: begin
				if (stat.y_is_nm1) begin
					prime_d = 1'b1;
					state_d = mrwt_pkg::ST_DONE;
				end else if (stat.s_left) begin
					state_d = mrwt_pkg::ST_SQR;
				end else begin
					prime_d = 1'b0;
					state_d = mrwt_pkg::ST_DONE;
				end
			end
			mrwt_pkg::ST_DONE: begin
				state_d = mrwt_pkg::ST_IDLE;
			end
			default: begin
				state_d = mrwt_pkg::ST_IDLE;
			end
		endcase
	end

	// Commands toward the datapath.
	always_comb begin
		cmd      = '{op: mrwt_pkg::OP_NONE, msel: mrwt_pkg::MS_Y_B, wr_y: 1'b0, wr_b: 1'b0};
		busy     = (state_q != mrwt_pkg::ST_IDLE);
		done     = (state_q == mrwt_pkg::ST_DONE);
		unique case (state_q)
			mrwt_pkg::ST_IDLE: begin
				if (start) begin
					cmd.op = mrwt_pkg::OP_LOAD;
				end
			end
			mrwt_pkg::ST_RED: begin
				if (!stat.red_done) begin
					cmd.op = mrwt_pkg::OP_RED_STEP;
				end
			end
			mrwt_pkg::ST_SPLIT: begin
				cmd.op = mrwt_pkg::OP_SPLIT;
			end
			mrwt_pkg::ST_PMUL: begin
				cmd.msel = mrwt_pkg::MS_Y_B;
				cmd.wr_y = 1'b1;
				cmd.op   = (sq_q == 2'd1) ? mrwt_pkg::OP_MUL_STEP : mrwt_pkg::OP_MUL_START;
			end
			mrwt_pkg::ST_PSQR: begin
				cmd.msel = mrwt_pkg::MS_B_B;
				cmd.wr_b = 1'b1;
				if (sq_q == 2'd1) begin
					cmd.op = stat.mul_done ? mrwt_pkg::OP_SHIFT_E : mrwt_pkg::OP_MUL_STEP;
				end else begin
					cmd.op = mrwt_pkg::OP_MUL_START;
				end
			end
			mrwt_pkg::ST_EVAL: begin
				// Count down s once before the first squaring so that s-1 remain.
				cmd.op = mrwt_pkg::OP_SHIFT_E;
			end
			mrwt_pkg::ST_SQR: begin
				cmd.msel = mrwt_pkg::MS_Y_Y;
				cmd.wr_y = 1'b1;
				cmd.op   = (sq_q == 2'd1) ? mrwt_pkg::OP_MUL_STEP : mrwt_pkg::OP_MUL_START;
			end
			mrwt_pkg::ST_SEVAL: begin
				cmd.op = mrwt_pkg::OP_SHIFT_E;
			end
			default: begin
			end
		endcase
	end

	assign probable_prime = prime_q;
	assign trivial_case   = triv_q;

endmodule

/* sv/miller_rabin_witness_test_core.sv */
// ----------------------------------------------------------------------------
// Miller-Rabin witness test core
// Strong probable prime test of one candidate against one base.
// ----------------------------------------------------------------------------
// A small or even candidate ends at the check and a degenerate base at
// the reduction; otherwise the test runs about 2*WIDTH modular products,
// each a bit-serial shift-and-add multiply.
// The core takes one item at a time; a new transfer is taken the cycle
// after done.
// The result shows for one cycle with done high; the receiver cannot stall.
// Reset: arst_n returns the controller to idle and clears busy and done.
module miller_rabin_witness_test_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [31:0] candidate,
	input  logic [31:0] witness,
	output logic        done,
	output logic        probable_prime,
	output logic        trivial_case
);

	mrwt_pkg::cmd_t  cmd;
	mrwt_pkg::stat_t stat;

	// Controller.
	mrwt_ctrl u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.stat           (stat),
		.cmd            (cmd),
		.done           (done),
		.probable_prime (probable_prime),
		.trivial_case   (trivial_case)
	);

	// Datapath.
	mrwt_datapath u_dp (
		.clk       (clk),
		.candidate (candidate),
		.witness   (witness),
		.cmd       (cmd),
		.stat      (stat)
	);

endmodule

/* sv/mrwt_checker.sv */
// ----------------------------------------------------------------------------
// Miller-Rabin port checker
// Watches the top-level ports for handshake and result ordering.
// ----------------------------------------------------------------------------
module mrwt_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done,
	input logic probable_prime,
	input logic trivial_case
);

	// A transfer starts work on the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("busy did not rise after transfer");

	// A result only appears while work is in flight.
	assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy) else $error("done without work in flight");

	// The block goes idle right after a result.
	assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy) else $error("busy held after result");

	// A result is a single-cycle strobe.
	assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done longer than one cycle");

	// The verdict flags carry known values whenever a result shows.
	assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !$isunknown({probable_prime, trivial_case}))
		else $error("unknown verdict on result");

endmodule

bind miller_rabin_witness_test_core mrwt_checker u_mrwt_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.start          (start),
	.busy           (busy),
	.done           (done),
	.probable_prime (probable_prime),
	.trivial_case   (trivial_case)
);
